// ===== rtl/convex_polygon_span_fill_assert.svh =====
// ----------------------------------------------------------------------------
// Convex polygon span fill assertion macros
// Shared concurrent assertion forms for the span fill block.
// ----------------------------------------------------------------------------
`ifndef CONVEX_POLYGON_SPAN_FILL_ASSERT_SVH
`define CONVEX_POLYGON_SPAN_FILL_ASSERT_SVH

// same-cycle implication
`define CPSF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPSF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cpsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Convex polygon span fill package
// Sizes, constants and sequencer states shared by the span fill modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsf_pkg;

    localparam int VERTEX_MAX   = 16;
    localparam int TABLE_ROWS   = 1024;
    localparam int FRAC_BITS    = 16;

    localparam int COORD_W      = 11;
    localparam int COLOR_W      = 24;
    localparam int ROW_W        = 12;
    localparam int VA_W         = $clog2(VERTEX_MAX);
    localparam int VC_W         = $clog2(VERTEX_MAX + 1);
    localparam int RA_W         = $clog2(TABLE_ROWS);
    localparam int SP_W         = $clog2(TABLE_ROWS + 1);
    localparam int XW           = COORD_W + FRAC_BITS;
    localparam int VTX_W        = 2 * COORD_W;
    localparam int ENT_W        = 2 * ROW_W;

    localparam logic [ROW_W-1:0]   EMPTY_LEFT   = '1;
    localparam logic [ROW_W-1:0]   EMPTY_RIGHT  = '0;
    localparam logic [VC_W-1:0]    MIN_VERTICES = VC_W'(3);
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 24'h00FF00;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MM_RD,
        ST_MM_UPD,
        ST_CLR,
        ST_E_RD0,
        ST_E_LD0,
        ST_E_RD,
        ST_E_LD,
        ST_E_DIV,
        ST_ROW_RD,
        ST_ROW_WR,
        ST_F_RD,
        ST_F_CHK
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/cpsf_ram.sv =====
// ----------------------------------------------------------------------------
// Span fill RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/cpsf_div.sv =====
// ----------------------------------------------------------------------------
// Span fill edge step divider
// Restoring divider, one quotient bit per cycle, for the fixed point x step.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsf_div
    import cpsf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [XW-1:0]      i_dividend,
    input  wire logic [COORD_W-1:0] i_divisor,
    output logic                    o_done,
    output logic      [XW-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(XW + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [XW-1:0]      r_q;
    logic [COORD_W-1:0] r_rem;
    logic [COORD_W-1:0] r_div;
    logic               r_done;
    logic [COORD_W:0]   trial;
    logic               take;

    assign trial = {r_rem, r_q[XW-1]};
    assign take  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(XW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[XW-2:0], take};
            r_rem <= take ? COORD_W'(trial - {1'b0, r_div}) : trial[COORD_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

// ===== rtl/convex_polygon_span_fill.sv =====
// ----------------------------------------------------------------------------
// Convex polygon span fill
// Vertex loader, edge table builder and span fetcher over a row table RAM.
// ----------------------------------------------------------------------------
// Vertex load: stored while idle. Closing vertex: min/max pass over the vertices, a clear
// of each table row, a read of the first vertex, then a read per edge plus, on a sloped
// edge, a divide and a read and write per table row (a read only per skipped row).
// Fetch: answers straight from idle when no span is left, else reads and checks rows in turn.
// Results show the cycle after the transaction ends; the receiver cannot stall.
// Synchronous active-low reset clears control state and loads the default color.
`default_nettype none

module convex_polygon_span_fill
    import cpsf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_mode,
    input  wire logic [COORD_W-1:0] i_vertex_x,
    input  wire logic [COORD_W-1:0] i_vertex_y,
    input  wire logic               i_vertex_last,
    input  wire logic               i_cfg_we,
    input  wire logic [COLOR_W-1:0] i_cfg_wdata,
    output logic                    o_result_strobe,
    output logic                    o_span_valid,
    output logic      [COORD_W-1:0] o_span_y,
    output logic      [COORD_W-1:0] o_span_left,
    output logic      [COORD_W-1:0] o_span_right,
    output logic      [COLOR_W-1:0] o_span_color,
    output logic                    o_fill_done
);

    t_state             r_state, n_state;
    logic [VC_W-1:0]    r_count;
    logic               r_ready;
    logic [COORD_W-1:0] r_lowest, r_highest;
    logic [SP_W-1:0]    r_span, r_frow, r_crow, r_cur;
    logic [COLOR_W-1:0] r_color;
    logic [VC_W-1:0]    r_vi;
    logic [COORD_W-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic [XW-1:0]      r_x, r_step;
    logic [COORD_W-1:0] r_y, r_yend;
    logic               r_rising;
    logic               r_strobe, r_valid, r_done;
    logic [COORD_W-1:0] r_oy, r_ol, r_or;
    logic [COLOR_W-1:0] r_ocol;

    logic               acc;
    logic [VC_W-1:0]    load_cnt, new_cnt;
    logic               v_we;
    logic [VA_W-1:0]    v_waddr, v_raddr;
    logic [VTX_W-1:0]   v_rdata;
    logic               row_we;
    logic [RA_W-1:0]    row_waddr, row_raddr;
    logic [ENT_W-1:0]   row_wdata, row_rdata;
    logic               div_start, div_done;
    logic [XW-1:0]      div_q, div_dividend;
    logic [COORD_W-1:0] div_divisor;

    logic [COORD_W-1:0] rd_x, rd_y, cur_x, cur_y, mm_lo, mm_hi;
    logic [ROW_W-1:0]   span_full;
    logic [SP_W-1:0]    span_clip;
    logic               swap, flat, rising;
    logic [COORD_W-1:0] a_x, a_y, b_x, b_y, dx, dy;
    logic [COORD_W-1:0] row_idx;
    logic               idx_in, last_row, last_edge;
    logic [XW:0]        x_up;
    logic [ROW_W-1:0]   lo_x, hi_x, cell_l, cell_r, new_l, new_r;
    logic [XW-1:0]      x_next;

    assign busy     = r_state != ST_IDLE;
    assign acc      = start && !busy;
    assign load_cnt = r_ready ? '0 : r_count;
    assign new_cnt  = (load_cnt < VC_W'(VERTEX_MAX)) ? load_cnt + VC_W'(1) : load_cnt;

    assign rd_x  = v_rdata[VTX_W-1:COORD_W];
    assign rd_y  = v_rdata[COORD_W-1:0];
    assign cur_x = (r_vi == r_count) ? r_first_x : rd_x;
    assign cur_y = (r_vi == r_count) ? r_first_y : rd_y;
    assign mm_lo = (r_vi == '0 || rd_y < r_lowest)  ? rd_y : r_lowest;
    assign mm_hi = (r_vi == '0 || rd_y > r_highest) ? rd_y : r_highest;
    assign span_full = ROW_W'(mm_hi) - ROW_W'(mm_lo) + ROW_W'(1);
    assign span_clip = (span_full > ROW_W'(TABLE_ROWS)) ? SP_W'(TABLE_ROWS)
                                                        : span_full[SP_W-1:0];

    assign swap   = r_prev_y > cur_y;
    assign flat   = r_prev_y == cur_y;
    assign a_x    = swap ? cur_x : r_prev_x;
    assign a_y    = swap ? cur_y : r_prev_y;
    assign b_x    = swap ? r_prev_x : cur_x;
    assign b_y    = swap ? r_prev_y : cur_y;
    assign rising = b_x >= a_x;
    assign dx     = rising ? b_x - a_x : a_x - b_x;
    assign dy     = b_y - a_y;
    assign div_dividend = {dx, FRAC_BITS'(0)};
    assign div_divisor  = dy;

    assign row_idx   = r_y - r_lowest;
    assign idx_in    = ROW_W'(row_idx) < ROW_W'(r_span);
    assign last_row  = (r_y + COORD_W'(1)) == r_yend;
    assign last_edge = r_vi == r_count;
    assign x_next    = r_rising ? r_x + r_step : r_x - r_step;

    assign x_up   = {1'b0, r_x} + (XW+1)'((1 << FRAC_BITS) - 1);
    assign lo_x   = x_up[XW:FRAC_BITS];
    assign hi_x   = {1'b0, r_x[XW-1:FRAC_BITS]};
    assign cell_l = row_rdata[ENT_W-1:ROW_W];
    assign cell_r = row_rdata[ROW_W-1:0];
    assign new_l  = (lo_x < cell_l) ? lo_x : cell_l;
    assign new_r  = (hi_x > cell_r) ? hi_x : cell_r;

    cpsf_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_MAX)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata ({i_vertex_x, i_vertex_y}),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    cpsf_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ROWS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    cpsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && i_mode == MODE_LOAD && i_vertex_last && new_cnt >= MIN_VERTICES) begin
                    n_state = ST_MM_RD;
                end else if (acc && i_mode == MODE_FETCH && r_ready && r_frow < r_span) begin
                    n_state = ST_F_RD;
                end
            end
            ST_MM_RD:  n_state = ST_MM_UPD;
            ST_MM_UPD: n_state = ((r_vi + VC_W'(1)) == r_count) ? ST_CLR : ST_MM_RD;
            ST_CLR:    n_state = ((r_crow + SP_W'(1)) == r_span) ? ST_E_RD0 : ST_CLR;
            ST_E_RD0:  n_state = ST_E_LD0;
            ST_E_LD0:  n_state = ST_E_RD;
            ST_E_RD:   n_state = ST_E_LD;
            ST_E_LD: begin
                if (!flat) begin
                    n_state = ST_E_DIV;
                end else begin
                    n_state = last_edge ? ST_IDLE : ST_E_RD;
                end
            end
            ST_E_DIV:  n_state = div_done ? ST_ROW_RD : ST_E_DIV;
            ST_ROW_RD: begin
                if (idx_in) begin
                    n_state = ST_ROW_WR;
                end else if (last_row) begin
                    n_state = last_edge ? ST_IDLE : ST_E_RD;
                end
            end
            ST_ROW_WR: begin
                if (!last_row) begin
                    n_state = ST_ROW_RD;
                end else begin
                    n_state = last_edge ? ST_IDLE : ST_E_RD;
                end
            end
            ST_F_RD:   n_state = ST_F_CHK;
            ST_F_CHK: begin
                if (cell_l > cell_r && r_frow < r_span) begin
                    n_state = ST_F_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        v_we      = 1'b0;
        v_waddr   = load_cnt[VA_W-1:0];
        v_raddr   = r_vi[VA_W-1:0];
        row_we    = 1'b0;
        row_waddr = r_crow[RA_W-1:0];
        row_wdata = {EMPTY_LEFT, EMPTY_RIGHT};
        row_raddr = row_idx[RA_W-1:0];
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                v_we = acc && i_mode == MODE_LOAD && load_cnt < VC_W'(VERTEX_MAX);
            end
            ST_CLR: begin
                row_we = 1'b1;
            end
            ST_E_RD0: begin
                v_raddr = '0;
            end
            ST_E_LD: begin
                div_start = !flat;
            end
            ST_ROW_WR: begin
                row_we    = 1'b1;
                row_waddr = row_idx[RA_W-1:0];
                row_wdata = {new_l, new_r};
            end
            ST_F_RD: begin
                row_raddr = r_frow[RA_W-1:0];
            end
            default: begin
                v_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ready  <= 1'b0;
            r_lowest <= '0;
            r_span   <= '0;
            r_frow   <= '0;
            r_color  <= COLOR_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    if (acc && i_mode == MODE_LOAD) begin
                        r_count <= new_cnt;
                        r_ready <= i_vertex_last;
                        if (r_ready || i_vertex_last) begin
                            r_span <= '0;
                            r_frow <= '0;
                        end
                        if (i_vertex_last) begin
                            r_vi <= '0;
                        end
                    end else if (acc && !(r_ready && r_frow < r_span)) begin
                        r_strobe <= 1'b1;
                        r_valid  <= 1'b0;
                        r_done   <= 1'b1;
                        r_oy     <= '0;
                        r_ol     <= '0;
                        r_or     <= '0;
                        r_ocol   <= '0;
                    end
                end
                ST_MM_UPD: begin
                    r_lowest  <= mm_lo;
                    r_highest <= mm_hi;
                    r_vi      <= r_vi + VC_W'(1);
                    r_span    <= span_clip;
                    r_crow    <= '0;
                end
                ST_CLR: begin
                    r_crow <= r_crow + SP_W'(1);
                end
                ST_E_LD0: begin
                    r_first_x <= rd_x;
                    r_first_y <= rd_y;
                    r_prev_x  <= rd_x;
                    r_prev_y  <= rd_y;
                    r_vi      <= VC_W'(1);
                end
                ST_E_LD: begin
                    r_prev_x <= cur_x;
                    r_prev_y <= cur_y;
                    r_x      <= {a_x, FRAC_BITS'(0)};
                    r_y      <= a_y;
                    r_yend   <= b_y;
                    r_rising <= rising;
                    if (flat && !last_edge) begin
                        r_vi <= r_vi + VC_W'(1);
                    end
                end
                ST_E_DIV: begin
                    r_step <= div_q;
                end
                ST_ROW_RD, ST_ROW_WR: begin
                    if (r_state == ST_ROW_WR || !idx_in) begin
                        r_x <= x_next;
                        r_y <= r_y + COORD_W'(1);
                        if (last_row && !last_edge) begin
                            r_vi <= r_vi + VC_W'(1);
                        end
                    end
                end
                ST_F_RD: begin
                    r_cur  <= r_frow;
                    r_frow <= r_frow + SP_W'(1);
                end
                ST_F_CHK: begin
                    if (cell_l <= cell_r) begin
                        r_strobe <= 1'b1;
                        r_valid  <= 1'b1;
                        r_done   <= 1'b0;
                        r_oy     <= COORD_W'(r_cur) + r_lowest;
                        r_ol     <= cell_l[COORD_W-1:0];
                        r_or     <= cell_r[COORD_W-1:0];
                        r_ocol   <= r_color;
                    end else if (!(r_frow < r_span)) begin
                        r_strobe <= 1'b1;
                        r_valid  <= 1'b0;
                        r_done   <= 1'b1;
                        r_oy     <= '0;
                        r_ol     <= '0;
                        r_or     <= '0;
                        r_ocol   <= '0;
                    end
                end
                default: begin
                    r_strobe <= 1'b0;
                end
            endcase
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_span_valid    = r_valid;
    assign o_fill_done     = r_done;
    assign o_span_y        = r_oy;
    assign o_span_left     = r_ol;
    assign o_span_right    = r_or;
    assign o_span_color    = r_ocol;

`include "convex_polygon_span_fill_assert.svh"

    `CPSF_ASSERT_IMP(a_strobe_idle, o_result_strobe, !busy, "result while busy")
    `CPSF_ASSERT_IMP(a_valid_xor_done, o_result_strobe, o_span_valid != o_fill_done,
        "span valid and done disagree")
    `CPSF_ASSERT_NXT(a_load_silent, start && !busy && i_mode == MODE_LOAD, !o_result_strobe,
        "vertex load produced a result")
    `CPSF_ASSERT_IMP(a_span_order, o_result_strobe && o_span_valid, o_span_left <= o_span_right,
        "span left beyond right")

endmodule

`default_nettype wire

// ===== dv/tb_convex_polygon_span_fill.sv =====
// ----------------------------------------------------------------------------
// Span fill testbench
// Drives vertex loads and span fetches against convex_polygon_span_fill,
// predicts each span from its own edge-table walk and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_convex_polygon_span_fill;
    import cpsf_pkg::*;

    localparam int LIMIT_CYCLES = 20000000;

    typedef enum logic [1:0] {
        IT_XACT,
        IT_CFG,
        IT_PAUSE
    } t_item_kind;

    typedef struct {
        t_item_kind         kind;
        logic               mode;
        logic [COORD_W-1:0] vx;
        logic [COORD_W-1:0] vy;
        logic               last;
        logic [COLOR_W-1:0] color;
    } t_item;

    typedef struct {
        logic               valid;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] right;
        logic [COLOR_W-1:0] color;
        logic               done;
    } t_span;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_mode;
    logic [COORD_W-1:0] i_vertex_x;
    logic [COORD_W-1:0] i_vertex_y;
    logic               i_vertex_last;
    logic               i_cfg_we;
    logic [COLOR_W-1:0] i_cfg_wdata;
    logic               o_result_strobe;
    logic               o_span_valid;
    logic [COORD_W-1:0] o_span_y;
    logic [COORD_W-1:0] o_span_left;
    logic [COORD_W-1:0] o_span_right;
    logic [COLOR_W-1:0] o_span_color;
    logic               o_fill_done;

    convex_polygon_span_fill i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_vertex_x      (i_vertex_x),
        .i_vertex_y      (i_vertex_y),
        .i_vertex_last   (i_vertex_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_strobe (o_result_strobe),
        .o_span_valid    (o_span_valid),
        .o_span_y        (o_span_y),
        .o_span_left     (o_span_left),
        .o_span_right    (o_span_right),
        .o_span_color    (o_span_color),
        .o_fill_done     (o_fill_done)
    );

    t_item  pending_items[$];
    t_span  expected_spans[$];

    // predictor state
    int unsigned        pv_x[VERTEX_MAX];
    int unsigned        pv_y[VERTEX_MAX];
    int unsigned        pv_count;
    int unsigned        prow_left[TABLE_ROWS];
    int unsigned        prow_right[TABLE_ROWS];
    int unsigned        plow_y;
    int unsigned        prow_span;
    int unsigned        pfetch_row;
    bit                 ptable_ready;
    logic [COLOR_W-1:0] pcolor;

    int     mismatches;
    int     cycles;
    int     quiet;
    int     n_loads;
    int     n_fetches;
    int     n_spans;
    int     n_cfg;
    int     n_sent;
    bit     took;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic walk_edge(int unsigned xa, int unsigned ya, int unsigned xb,
                             int unsigned yb);
        int unsigned t;
        int unsigned idx;
        int unsigned lo;
        int unsigned hi;
        longint unsigned x;
        longint unsigned step;
        bit rising;
        if (ya == yb) return;
        if (ya > yb) begin
            t = xa; xa = xb; xb = t;
            t = ya; ya = yb; yb = t;
        end
        rising = xb >= xa;
        step = (longint'(rising ? xb - xa : xa - xb) << FRAC_BITS) / (yb - ya);
        x = longint'(xa) << FRAC_BITS;
        for (int unsigned y = ya; y < yb; y++) begin
            idx = y - plow_y;
            if (idx < prow_span) begin
                lo = int'((x + (64'd1 << FRAC_BITS) - 1) >> FRAC_BITS);
                hi = int'(x >> FRAC_BITS);
                if (lo < prow_left[idx]) prow_left[idx] = lo & 12'hFFF;
                if (hi > prow_right[idx]) prow_right[idx] = hi & 12'hFFF;
            end
            x = rising ? x + step : x - step;
        end
    endtask

    task automatic build_rows();
        int unsigned lo;
        int unsigned hi;
        int unsigned j;
        prow_span = 0;
        plow_y = 0;
        pfetch_row = 0;
        if (pv_count < MIN_VERTICES) return;
        lo = pv_y[0];
        hi = pv_y[0];
        for (int unsigned i = 1; i < pv_count; i++) begin
            if (pv_y[i] < lo) lo = pv_y[i];
            if (pv_y[i] > hi) hi = pv_y[i];
        end
        plow_y = lo;
        prow_span = (hi - lo + 1 > TABLE_ROWS) ? TABLE_ROWS : hi - lo + 1;
        for (int unsigned i = 0; i < prow_span; i++) begin
            prow_left[i] = EMPTY_LEFT;
            prow_right[i] = EMPTY_RIGHT;
        end
        for (int unsigned i = 0; i < pv_count; i++) begin
            j = (i + 1 == pv_count) ? 0 : i + 1;
            walk_edge(pv_x[i], pv_y[i], pv_x[j], pv_y[j]);
        end
    endtask

    task automatic predict_span(logic mode, logic [COORD_W-1:0] vx,
                                logic [COORD_W-1:0] vy, logic last);
        t_span s;
        int unsigned r;
        if (mode == MODE_LOAD) begin
            n_loads++;
            if (ptable_ready) begin
                ptable_ready = 0;
                pv_count = 0;
                prow_span = 0;
                pfetch_row = 0;
            end
            if (pv_count < VERTEX_MAX) begin
                pv_x[pv_count] = vx;
                pv_y[pv_count] = vy;
                pv_count++;
            end
            if (last) begin
                build_rows();
                ptable_ready = 1;
            end
            return;
        end
        n_fetches++;
        s = '{valid: 1'b0, y: '0, left: '0, right: '0, color: '0, done: 1'b1};
        if (ptable_ready) begin
            while (pfetch_row < prow_span) begin
                r = pfetch_row;
                pfetch_row++;
                if (prow_left[r] <= prow_right[r]) begin
                    s.valid = 1'b1;
                    s.y = COORD_W'(r + plow_y);
                    s.left = COORD_W'(prow_left[r]);
                    s.right = COORD_W'(prow_right[r]);
                    s.color = pcolor;
                    s.done = 1'b0;
                    n_spans++;
                    break;
                end
            end
        end
        expected_spans = {expected_spans, s};
    endtask

    // monitor and predictor
    always @(posedge i_clk) begin
        t_span e;
        if (i_rst_n) begin
            cycles++;
            if (cycles >= LIMIT_CYCLES) begin
                $display("timeout after %0d cycles", cycles);
                $display("end of test: mismatches");
                $finish;
            end else begin
                if (o_result_strobe) begin
                    if (expected_spans.size() == 0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("unexpected result y=%0d", o_span_y);
                    end else begin
                        e = expected_spans.pop_front();
                        if (o_span_valid !== e.valid || o_span_y !== e.y ||
                            o_span_left !== e.left || o_span_right !== e.right ||
                            o_span_color !== e.color || o_fill_done !== e.done) begin
                            mismatches++;
                            if (mismatches <= 10) begin
                                $write("mismatch exp v=%0b y=%0d l=%0d r=%0d c=%h d=%0b",
                                       e.valid, e.y, e.left, e.right, e.color, e.done);
                                $display(" got v=%0b y=%0d l=%0d r=%0d c=%h d=%0b",
                                         o_span_valid, o_span_y, o_span_left,
                                         o_span_right, o_span_color, o_fill_done);
                            end
                        end
                    end
                end
                if (i_cfg_we) pcolor = i_cfg_wdata;
                took = start && !busy;
                if (took) predict_span(i_mode, i_vertex_x, i_vertex_y, i_vertex_last);
                quiet = (!busy && !start && !o_result_strobe) ? quiet + 1 : 0;
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_item it;
        bit calm;
        bit cfg_now;
        if (i_rst_n) begin
            cfg_now = 1'b0;
            if (!(start && !took)) begin
                calm = n_sent >= 300 && n_sent < 420;
                if (pending_items.size() == 0) begin
                    start <= 1'b0;
                end else if (pending_items[0].kind != IT_XACT) begin
                    start <= 1'b0;
                    if (quiet >= 4 && expected_spans.size() == 0) begin
                        it = pending_items.pop_front();
                        if (it.kind == IT_CFG) begin
                            cfg_now = 1'b1;
                            i_cfg_wdata <= it.color;
                            n_cfg++;
                        end
                    end
                end else if (!calm && $urandom_range(0, 99) < 14) begin
                    start <= 1'b0;
                end else begin
                    it = pending_items.pop_front();
                    start <= 1'b1;
                    i_mode <= it.mode;
                    i_vertex_x <= it.vx;
                    i_vertex_y <= it.vy;
                    i_vertex_last <= it.last;
                    n_sent++;
                end
            end
            i_cfg_we <= cfg_now;
        end
    end

    task automatic push_xact(logic mode, int unsigned x, int unsigned y, logic last);
        t_item it;
        it = '{kind: IT_XACT, mode: mode, vx: COORD_W'(x), vy: COORD_W'(y),
               last: last, color: '0};
        pending_items = {pending_items, it};
    endtask

    task automatic push_ctrl(t_item_kind kind, logic [COLOR_W-1:0] color);
        t_item it;
        it = '{kind: kind, mode: MODE_LOAD, vx: '0, vy: '0, last: 1'b0, color: color};
        pending_items = {pending_items, it};
    endtask

    task automatic push_fetches(int n);
        repeat (n) push_xact(MODE_FETCH, $urandom, $urandom, 1'($urandom));
    endtask

    task automatic push_polygon();
        int n;
        int h;
        int base_y;
        int cx;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) n = $urandom_range(1, 2);
        else if (roll < 13) n = $urandom_range(17, 18);
        else n = $urandom_range(3, 7);
        if ($urandom_range(0, 99) < 3) begin
            h = $urandom_range(1030, 2047);
            base_y = 0;
        end else begin
            h = $urandom_range(0, 30);
            base_y = $urandom_range(0, 2047 - h);
        end
        cx = $urandom_range(0, 2047);
        for (int i = 0; i < n; i++)
            push_xact(MODE_LOAD,
                      ($urandom_range(0, 1)) ? $urandom_range(0, 2047)
                                             : (cx + $urandom_range(0, 40)) % 2048,
                      base_y + $urandom_range(0, h), i == n - 1);
        if (h > 100) push_fetches($urandom_range(5, 40));
        else if ($urandom_range(0, 99) < 80) push_fetches(h + 3);
        else push_fetches($urandom_range(0, h));
    endtask

    initial begin
        int polys;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = MODE_LOAD;
        i_vertex_x = '0;
        i_vertex_y = '0;
        i_vertex_last = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        pcolor = COLOR_RESET;
        pv_count = 0;
        plow_y = 0;
        prow_span = 0;
        pfetch_row = 0;
        ptable_ready = 0;
        took = 0;
        polys = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fetch before any polygon, then a two-vertex polygon
        push_fetches(1);
        push_xact(MODE_LOAD, 5, 5, 0);
        push_xact(MODE_LOAD, 9, 9, 1);
        push_fetches(2);
        // extreme triangle with a horizontal edge
        push_xact(MODE_LOAD, 0, 2037, 0);
        push_xact(MODE_LOAD, 2047, 2037, 0);
        push_xact(MODE_LOAD, 1024, 2047, 1);
        push_fetches(12);
        push_ctrl(IT_CFG, 24'hFFFFFF);
        push_xact(MODE_LOAD, 2047, 0, 0);
        push_xact(MODE_LOAD, 0, 3, 0);
        push_xact(MODE_LOAD, 2047, 6, 1);
        push_fetches(4);

        while (pending_items.size() < 700) begin
            push_polygon();
            polys++;
            if (polys % 6 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_ctrl(IT_CFG, 24'h000000);
                    1: push_ctrl(IT_CFG, 24'hFFFFFF);
                    default: push_ctrl(IT_CFG, $urandom);
                endcase
            end else if (polys % 5 == 0) begin
                push_ctrl(IT_PAUSE, '0);
            end
            if ($urandom_range(0, 9) == 0) push_fetches($urandom_range(1, 3));
        end

        wait (pending_items.size() == 0 && !start);
        wait (expected_spans.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("covered %0d polygons, %0d loads, %0d fetches, %0d spans, %0d color writes",
                 polys + 3, n_loads, n_fetches, n_spans, n_cfg);
        if (mismatches == 0 && expected_spans.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_spans.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
